FILE: src/slu_pkg.sv
// Shared types, character codes and helper functions for the string literal unescaper.
// Used by every module of the block; depends on nothing.
package slu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_string;
    logic       last_of_string;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       last_in_run;
  } res_t;

  // one decoded request: up to two results
  typedef struct packed {
    logic [7:0] byte0;
    logic       end0;
    logic [7:0] byte1;
    logic       end1;
    logic       two;
  } act_t;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhBody   = 3'd1,
    PhQuote  = 3'd2,
    PhDollar = 3'd3,
    PhHex    = 3'd4
  } phase_e;

  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChLowL   = 8'h6c;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChFf     = 8'h0c;
  localparam logic [7:0] ChTab    = 8'h09;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // bit 4 set when c is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: src/slu_fifo.sv
// Small queue of decoded requests between the decoder and the result sequencer.
// Depends on slu_pkg for the entry type.
module slu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  slu_pkg::act_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output slu_pkg::act_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slu_pkg::act_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

FILE: src/slu_front.sv
// Decoder: accepts literal bytes, tracks escape lookahead and classifies each request.
// Depends on slu_pkg; feeds slu_fifo.
module slu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  slu_pkg::req_t req_i,
  output logic          wr_o,
  output slu_pkg::act_t act_o
);

  slu_pkg::phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [1:0] n;
  logic [7:0] c, lc;
  logic [4:0] hx_c, hx_h;

  always_comb begin
    c      = req_i.in_byte;
    lc     = slu_pkg::to_lower(c);
    hx_c   = slu_pkg::hex_value(c);
    hx_h   = slu_pkg::hex_value(held_q);
    phase_d = phase_q;
    held_d  = held_q;
    n       = 2'd0;
    act_o   = '0;
    if (req_i.first_of_string) begin
      if (req_i.last_of_string) begin
        n = 2'd1;
        act_o.end0 = 1'b1;
        phase_d = slu_pkg::PhIdle;
      end else begin
        phase_d = slu_pkg::PhBody;
      end
    end else if (phase_q == slu_pkg::PhIdle) begin
      n = 2'd0;
    end else if (req_i.last_of_string) begin
      phase_d = slu_pkg::PhIdle;
      if (phase_q == slu_pkg::PhQuote || phase_q == slu_pkg::PhHex) begin
        n = 2'd2;
        act_o.byte0 = (phase_q == slu_pkg::PhQuote) ? slu_pkg::ChQuote : held_q;
        act_o.end1  = 1'b1;
      end else begin
        n = 2'd1;
        act_o.end0 = 1'b1;
      end
    end else begin
      case (phase_q)
        slu_pkg::PhQuote: begin
          act_o.byte0 = slu_pkg::ChQuote;
          n = 2'd1;
          if (c == slu_pkg::ChQuote) begin
            phase_d = slu_pkg::PhBody;
          end else if (c == slu_pkg::ChDollar) begin
            phase_d = slu_pkg::PhDollar;
          end else begin
            phase_d = slu_pkg::PhBody;
            act_o.byte1 = c;
            n = 2'd2;
          end
        end
        slu_pkg::PhDollar: begin
          phase_d = slu_pkg::PhBody;
          n = 2'd1;
          if (lc == slu_pkg::ChLowL) begin
            act_o.byte0 = slu_pkg::ChLf;
          end else if (lc == slu_pkg::ChLowN) begin
            act_o.byte0 = slu_pkg::ChCr;
            act_o.byte1 = slu_pkg::ChLf;
            n = 2'd2;
          end else if (lc == slu_pkg::ChLowP) begin
            act_o.byte0 = slu_pkg::ChFf;
          end else if (lc == slu_pkg::ChLowR) begin
            act_o.byte0 = slu_pkg::ChCr;
          end else if (lc == slu_pkg::ChLowT) begin
            act_o.byte0 = slu_pkg::ChTab;
          end else if (hx_c[4]) begin
            held_d  = c;
            phase_d = slu_pkg::PhHex;
            n = 2'd0;
          end else begin
            act_o.byte0 = c;
          end
        end
        slu_pkg::PhHex: begin
          if (hx_c[4] && hx_h[4]) begin
            phase_d = slu_pkg::PhBody;
            act_o.byte0 = {hx_h[3:0], hx_c[3:0]};
            n = 2'd1;
          end else begin
            act_o.byte0 = held_q;
            n = 2'd1;
            if (c == slu_pkg::ChQuote) begin
              phase_d = slu_pkg::PhQuote;
            end else if (c == slu_pkg::ChDollar) begin
              phase_d = slu_pkg::PhDollar;
            end else begin
              phase_d = slu_pkg::PhBody;
              act_o.byte1 = c;
              n = 2'd2;
            end
          end
        end
        default: begin
          if (c == slu_pkg::ChQuote) begin
            phase_d = slu_pkg::PhQuote;
          end else if (c == slu_pkg::ChDollar) begin
            phase_d = slu_pkg::PhDollar;
          end else begin
            phase_d = slu_pkg::PhBody;
            act_o.byte0 = c;
            n = 2'd1;
          end
        end
      endcase
    end
    act_o.two = (n == 2'd2);
    wr_o = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slu_pkg::PhIdle;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: src/slu_back.sv
// Result sequencer: expands queued requests into single results behind an output register.
// Depends on slu_pkg; reads from slu_fifo.
module slu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slu_pkg::act_t act_i,
  input  logic          act_empty_i,
  output logic          act_rd_o,
  output slu_pkg::res_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);

  logic          out_valid_q, out_valid_d;
  slu_pkg::res_t res_q, res_d;
  logic          idx_q, idx_d;
  logic          load;

  assign load = (!out_valid_q || pop_i) && !act_empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    res_d       = res_q;
    act_rd_o    = 1'b0;
    if (!out_valid_q || pop_i) begin
      out_valid_d = !act_empty_i;
    end
    if (load) begin
      if (!idx_q) begin
        res_d.out_byte    = act_i.byte0;
        res_d.string_end  = act_i.end0;
        res_d.byte_valid  = !act_i.end0;
        res_d.last_in_run = !act_i.two;
        idx_d    = act_i.two;
        act_rd_o = !act_i.two;
      end else begin
        res_d.out_byte    = act_i.byte1;
        res_d.string_end  = act_i.end1;
        res_d.byte_valid  = !act_i.end1;
        res_d.last_in_run = 1'b1;
        idx_d    = 1'b0;
        act_rd_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o   = res_q;
  assign empty_o = !out_valid_q;

  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (!act_empty_i && act_i.two))
    else $error("second result pending without a two-result request");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.string_end) |-> (res_q.last_in_run && !res_q.byte_valid))
    else $error("string end result not last of its run");

  a_valid_xor_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.byte_valid != res_q.string_end))
    else $error("result is neither a byte nor a string end");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !idx_q && act_i.two) |=> (out_valid_q && !res_q.last_in_run))
    else $error("first of two results marked last");

endmodule

FILE: src/string_literal_unescape.sv
// Top level of the string literal unescaper: decoder, request queue, result sequencer.
// Depends on slu_pkg, slu_front, slu_fifo and slu_back.
//
// Usage: bytes of a quoted literal enter on req_i with push; a request is taken at a
// clock edge with push high and full low. first_of_string marks the opening byte and
// last_of_string the closing byte; both are dropped. Each request yields zero, one or
// two results (escape $N and flushed lookahead give two); the closing byte yields a
// result with string_end set. Results leave on res_o while empty is low and are taken
// at an edge with pop high. last_in_run flags the last result of one request.
// A request reaches res_o through the queue and the output register: the decoder writes
// the queue at the edge that takes the request, and the sequencer loads the output
// register from the queue once it is free. Throughput: one request per cycle as long as
// each yields at most one result and pop stays high; the sequencer emits one result per
// cycle while popped, so two-result requests fill the queue of QueueDepth entries and then
// hold full. When the receiver stalls the output register and queue hold, and full rises
// once the queue fills. Reset empties queue and output and returns the decoder to idle.
module string_literal_unescape #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  slu_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output slu_pkg::res_t res_o
);

  logic          accept;
  logic          act_wr;
  slu_pkg::act_t act_in, act_out;
  logic          act_rd, act_empty;

  assign accept = push && !full;

  slu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .wr_o     (act_wr),
    .act_o    (act_in)
  );

  slu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (act_wr),
    .wdata_i (act_in),
    .full_o  (full),
    .rd_i    (act_rd),
    .rdata_o (act_out),
    .empty_o (act_empty)
  );

  slu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_i       (act_out),
    .act_empty_i (act_empty),
    .act_rd_o    (act_rd),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
